@@ rtl/c3zpc_pkg.sv @@
// Shared constants, types and helpers for the 3x3 convolution block.
package c3zpc_pkg;
	localparam int WidthMax = 1024;
	localparam int ColW = $clog2(WidthMax);
	localparam int AddrW = ColW + 1;
	localparam int SumW = 30;

	typedef enum logic [2:0] {
		REG_KERNEL = 3'd0,
		REG_DIVISOR = 3'd1,
		REG_OFFSET = 3'd2,
		REG_MAX = 3'd3,
		REG_WIDTH = 3'd4,
		REG_HEIGHT = 3'd5
	} reg_idx_t;

	// One pending result request for the filter datapath
	typedef struct packed {
		logic [2:0] dr;
		logic [2:0] dc;
		logic [15:0] orow;
		logic [ColW-1:0] ocol;
		logic last;
	} job_t;

	// Sign-extend coefficient k from the packed kernel word
	function automatic logic signed [6:0] coeff(input logic [62:0] kw, input int k);
		coeff = signed'(kw[7*k +: 7]);
	endfunction
endpackage

@@ rtl/c3zpc_div.sv @@
// Iterative signed divide (truncating toward zero) with offset add and clamp.
module c3zpc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [c3zpc_pkg::SumW-1:0] sum,
	input logic [7:0] divisor,
	input logic signed [10:0] offset,
	input logic [15:0] clamp_max,
	output logic busy,
	output logic done,
	output logic [15:0] result
);
	localparam int MagW = c3zpc_pkg::SumW;
	localparam int CntW = $clog2(MagW + 1);

	logic [MagW-1:0] quo_q;
	logic [8:0] rem_q;
	logic [7:0] div_q;
	logic neg_q;
	logic [CntW-1:0] cnt_q;
	logic run_q;
	logic [8:0] trial;
	logic [8:0] rem_sh;
	logic signed [MagW+1:0] q_s;
	logic signed [MagW+1:0] res;

	assign rem_sh = {rem_q[7:0], quo_q[MagW-1]};
	assign trial = rem_sh - {1'b0, div_q};

	// Restoring division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			div_q <= 8'd1;
			neg_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(MagW);
				rem_q <= '0;
				neg_q <= sum[MagW-1];
				quo_q <= sum[MagW-1] ? MagW'(-sum) : MagW'(sum);
				div_q <= (divisor == 8'd0) ? 8'd1 : divisor;
			end else if (run_q) begin
				if (!trial[8]) begin
					rem_q <= trial;
					quo_q <= {quo_q[MagW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[MagW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Sign, offset and clamp on the finished quotient
	always_comb begin
		q_s = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
		res = q_s + (MagW+2)'(offset);
		if (res < 0) result = 16'd0;
		else if (res > $signed({{(MagW-14){1'b0}}, clamp_max})) result = clamp_max;
		else result = res[15:0];
	end

	assign busy = run_q || start;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !run_q)
		else $error("divider done while running");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> run_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("divider done held two cycles");
endmodule

@@ rtl/conv3x3_zero_pad_clamp.sv @@
// 3x3 convolution, zero padding, divide, offset and clamp on a raster stream.
// Steps: line-store read, planning, then per result a MAC step, a divider launch, the serial
// divide and an output step; each pixel gives 0 to 4 results.
// Throughput is set by the shared serial divider; the next pixel waits for the last result.
// Reset: registers to their defaults, window zero, position row 0 col 0;
// the line store is not cleared, unreceived rows are masked by position.
module conv3x3_zero_pad_clamp (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [2:0] wr_index,
	input logic [62:0] wr_data,
	input logic valid_in,
	output logic stall_in,
	input logic [15:0] pixel,
	output logic valid_out,
	input logic stall_out,
	output logic [15:0] out_pixel,
	output logic [15:0] out_row,
	output logic [c3zpc_pkg::ColW-1:0] out_col,
	output logic run_last
);
	localparam int ColW = c3zpc_pkg::ColW;
	localparam int AddrW = c3zpc_pkg::AddrW;
	localparam int SumW = c3zpc_pkg::SumW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_PLAN, ST_MAC, ST_START, ST_DIV, ST_OUT
	} state_t;

	logic [62:0] kern_q;
	logic [7:0] divisor_q;
	logic signed [10:0] offset_q;
	logic [15:0] max_q;
	logic [10:0] width_q;
	logic [15:0] height_q;

	logic [15:0] mem [2*c3zpc_pkg::WidthMax];
	logic [15:0] rd_old_q, rd_prev_q;
	logic [15:0] win_q [3][3];
	logic [15:0] row_q;
	logic [ColW-1:0] col_q;
	logic [15:0] px_q;
	state_t state_q;
	c3zpc_pkg::job_t jobs_q [4];
	logic [3:0] jv_q;
	logic [1:0] jsel;
	logic signed [SumW-1:0] sum_q;
	logic [10:0] w_eff;
	logic [15:0] h_eff;
	logic [15:0] r_use;
	logic [ColW-1:0] c_use;
	logic c_last, r_last;
	logic div_start, div_busy, div_done;
	logic [15:0] div_res;
	logic signed [SumW-1:0] mac;
	c3zpc_pkg::job_t cj;

	// Effective geometry and current position
	always_comb begin
		w_eff = (width_q == 11'd0) ? 11'd1 :
			(width_q > 11'(c3zpc_pkg::WidthMax)) ? 11'(c3zpc_pkg::WidthMax) : width_q;
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
		c_use = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
		r_use = (row_q >= h_eff) ? 16'd0 : row_q;
		c_last = ({1'b0, c_use} == w_eff - 11'd1);
		r_last = (r_use == h_eff - 16'd1);
	end

	// Lowest pending result
	always_comb begin
		priority if (jv_q[0]) jsel = 2'd0;
		else if (jv_q[1]) jsel = 2'd1;
		else if (jv_q[2]) jsel = 2'd2;
		else jsel = 2'd3;
		cj = jobs_q[jsel];
	end

	// Weighted sum over the window with padding masks;
	// results on the current row or column read the window one step down or right
	always_comb begin
		logic [1:0] wi, wj;
		mac = '0;
		wi = '0;
		wj = '0;
		for (int dy = 0; dy < 3; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				if (cj.dr[dy] && cj.dc[dx]) begin
					wi = 2'(dy) + 2'(jsel[1]);
					wj = 2'(dx) + 2'(jsel[0]);
					mac = mac + SumW'(c3zpc_pkg::coeff(kern_q, dy*3+dx)) *
						$signed({1'b0, win_q[wi][wj]});
				end
			end
		end
	end

	assign stall_in = (state_q != ST_IDLE);
	assign div_start = (state_q == ST_START);

	c3zpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .sum(sum_q),
		.divisor(divisor_q), .offset(offset_q), .clamp_max(max_q),
		.busy(div_busy), .done(div_done), .result(div_res)
	);

	// Line store: read both rows at accept, write new pixel
	always_ff @(posedge clk) begin
		if (valid_in && !stall_in) begin
			rd_old_q <= mem[{r_use[0], c_use}];
			rd_prev_q <= mem[{~r_use[0], c_use}];
			mem[AddrW'({r_use[0], c_use})] <= pixel;
		end
	end

	// Config, position, window, sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q <= 63'd1 << 28;
			divisor_q <= 8'd1;
			offset_q <= '0;
			max_q <= 16'd255;
			width_q <= 11'd640;
			height_q <= 16'd480;
			row_q <= '0;
			col_q <= '0;
			px_q <= '0;
			sum_q <= '0;
			state_q <= ST_IDLE;
			jv_q <= '0;
			valid_out <= 1'b0;
			run_last <= 1'b0;
			out_pixel <= '0;
			out_row <= '0;
			out_col <= '0;
			for (int i = 0; i < 4; i++) jobs_q[i] <= '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					c3zpc_pkg::REG_KERNEL: kern_q <= wr_data;
					c3zpc_pkg::REG_DIVISOR: divisor_q <= wr_data[7:0];
					c3zpc_pkg::REG_OFFSET: offset_q <= wr_data[10:0];
					c3zpc_pkg::REG_MAX: max_q <= wr_data[15:0];
					c3zpc_pkg::REG_WIDTH: begin
						width_q <= wr_data[10:0]; row_q <= '0; col_q <= '0;
					end
					c3zpc_pkg::REG_HEIGHT: begin
						height_q <= wr_data[15:0]; row_q <= '0; col_q <= '0;
					end
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (valid_in) begin
						px_q <= pixel;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// Shift window, plan results (masks are window-relative rows/cols)
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= rd_old_q;
					win_q[1][2] <= rd_prev_q;
					win_q[2][2] <= px_q;
					jobs_q[0] <= '{dr: {1'b1, 1'b1, r_use >= 16'd2},
						dc: {1'b1, 1'b1, c_use >= ColW'(2)},
						orow: r_use - 16'd1, ocol: c_use - ColW'(1), last: 1'b0};
					jobs_q[1] <= '{dr: {1'b1, 1'b1, r_use >= 16'd2},
						dc: {1'b0, 1'b1, c_use != '0},
						orow: r_use - 16'd1, ocol: c_use, last: 1'b0};
					jobs_q[2] <= '{dr: {1'b0, 1'b1, r_use != 16'd0},
						dc: {1'b1, 1'b1, c_use >= ColW'(2)},
						orow: r_use, ocol: c_use - ColW'(1), last: 1'b0};
					jobs_q[3] <= '{dr: {1'b0, 1'b1, r_use != 16'd0},
						dc: {1'b0, 1'b1, c_use != '0},
						orow: r_use, ocol: c_use, last: 1'b0};
					jv_q <= {r_last && c_last, r_last && c_use != '0,
						r_use != 16'd0 && c_last, r_use != 16'd0 && c_use != '0};
					if (c_last) begin
						col_q <= '0;
						row_q <= r_last ? 16'd0 : r_use + 16'd1;
					end else begin
						col_q <= c_use + ColW'(1);
						row_q <= r_use;
					end
					state_q <= ST_PLAN;
				end
				ST_PLAN: state_q <= (jv_q == '0) ? ST_IDLE : ST_MAC;
				ST_MAC: begin
					sum_q <= mac;
					state_q <= ST_START;
				end
				// Divider takes the registered sum here
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						out_pixel <= div_res;
						out_row <= cj.orow;
						out_col <= cj.ocol;
						run_last <= ((jv_q & ~(4'b1 << jsel)) == '0);
						valid_out <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!stall_out) begin
						valid_out <= 1'b0;
						jv_q[jsel] <= 1'b0;
						state_q <= run_last ? ST_IDLE : ST_MAC;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> state_q == ST_OUT)
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_busy || div_done)
		else $error("divider idle while waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && stall_out |=> valid_out && $stable(out_pixel))
		else $error("stalled result changed");
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the 3x3 zero-padded convolution with divide, offset and clamp.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [62:0] wr_data = '0;
	logic valid_in = 1'b0;
	logic stall_in;
	logic [15:0] pixel = '0;
	logic valid_out;
	logic stall_out = 1'b0;
	logic [15:0] out_pixel;
	logic [15:0] out_row;
	logic [c3zpc_pkg::ColW-1:0] out_col;
	logic run_last;

	conv3x3_zero_pad_clamp dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct {
		logic [15:0] level;
		logic [15:0] row;
		logic [c3zpc_pkg::ColW-1:0] col;
		logic last;
	} pix_result_t;

	// Shadow of the configuration and the filter state
	logic [62:0] m_kernel;
	logic [7:0] m_div;
	logic [10:0] m_off;
	logic [15:0] m_max;
	logic [10:0] m_width;
	logic [15:0] m_height;
	logic [15:0] m_lines [0:2*c3zpc_pkg::WidthMax-1];
	logic [15:0] m_win [0:2][0:2];
	int m_row, m_col;

	logic [15:0] pixel_q [$];
	pix_result_t filtered_q [$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_arm = 1'b0;
	int hold_cnt = 0;
	bit stall_pat_on = 1'b1;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic int eff_w();
		int w;
		w = int'(m_width);
		if (w < 1) w = 1;
		if (w > c3zpc_pkg::WidthMax) w = c3zpc_pkg::WidthMax;
		return w;
	endfunction

	function automatic int eff_h();
		return (m_height == 0) ? 1 : int'(m_height);
	endfunction

	function automatic logic [15:0] filter_level(input int orow, input int ocol,
			input int r, input int c, input int w, input int h);
		longint sum, d, res;
		int pr, pc, wr, wc;
		logic signed [6:0] k;
		sum = 0;
		for (int dy = -1; dy <= 1; dy++)
			for (int dx = -1; dx <= 1; dx++) begin
				pr = orow + dy;
				pc = ocol + dx;
				wr = pr - r + 2;
				wc = pc - c + 2;
				if (pr < 0 || pr >= h || pc < 0 || pc >= w) continue;
				if (wr < 0 || wr > 2 || wc < 0 || wc > 2) continue;
				k = m_kernel[7*((dy+1)*3+(dx+1)) +: 7];
				sum += longint'(k) * longint'(m_win[wr][wc]);
			end
		d = (m_div == 0) ? longint'(1) : longint'(m_div);
		res = sum / d + longint'($signed(m_off));
		if (res > longint'(m_max)) res = longint'(m_max);
		if (res < 0) res = 0;
		return res[15:0];
	endfunction

	// Advance the shadow state by one pixel and queue what it produces
	task automatic predict_pixel(input logic [15:0] px);
		int w, h, r, c, so, sp, n0;
		pix_result_t e;
		w = eff_w();
		h = eff_h();
		r = m_row;
		c = m_col;
		if (c >= w) c = 0;
		if (r >= h) r = 0;
		so = (r & 1) * c3zpc_pkg::WidthMax + c;
		sp = ((r + 1) & 1) * c3zpc_pkg::WidthMax + c;
		for (int i = 0; i < 3; i++) begin
			m_win[i][0] = m_win[i][1];
			m_win[i][1] = m_win[i][2];
		end
		m_win[0][2] = m_lines[so];
		m_win[1][2] = m_lines[sp];
		m_win[2][2] = px;
		m_lines[so] = px;
		n0 = filtered_q.size();
		e.last = 1'b0;
		if (r >= 1 && c >= 1) begin
			e.level = filter_level(r-1, c-1, r, c, w, h);
			e.row = 16'(r - 1); e.col = c3zpc_pkg::ColW'(c - 1);
			filtered_q.insert(filtered_q.size(), e);
		end
		if (r >= 1 && c == w - 1) begin
			e.level = filter_level(r-1, c, r, c, w, h);
			e.row = 16'(r - 1); e.col = c3zpc_pkg::ColW'(c);
			filtered_q.insert(filtered_q.size(), e);
		end
		if (r == h - 1) begin
			if (c >= 1) begin
				e.level = filter_level(r, c-1, r, c, w, h);
				e.row = 16'(r); e.col = c3zpc_pkg::ColW'(c - 1);
				filtered_q.insert(filtered_q.size(), e);
			end
			if (c == w - 1) begin
				e.level = filter_level(r, c, r, c, w, h);
				e.row = 16'(r); e.col = c3zpc_pkg::ColW'(c);
				filtered_q.insert(filtered_q.size(), e);
			end
		end
		if (filtered_q.size() > n0) filtered_q[filtered_q.size()-1].last = 1'b1;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		m_row = r;
		m_col = c;
	endtask

	// Sender: bursts and gaps, payload held while stalled
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (valid_in && !stall_in) predict_pixel(pixel);
			if (!valid_in || !stall_in) begin
				if (valid_in) void'(pixel_q.pop_front());
				if (gap_left > 0) begin
					gap_left--;
					valid_in <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					valid_in <= 1'b1;
					pixel <= pixel_q[0];
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(12, 0);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 0);
					end
				end else valid_in <= 1'b0;
			end
		end
	end

	// Receiver stall pattern, with a long hold-off counted here while armed
	always @(posedge clk) begin
		if (!hold_arm) hold_cnt = 0;
		else if (hold_cnt < HOLD_CYCLES) hold_cnt++;
		if (hold_arm && hold_cnt < HOLD_CYCLES) stall_out <= 1'b1;
		else if (!stall_pat_on) stall_out <= 1'b0;
		else stall_out <= ($urandom_range(3, 0) == 0);
	end

	// Result checker
	always @(posedge clk) begin
		pix_result_t e;
		if (arst_n) begin
			if ((valid_in && !stall_in) || (valid_out && !stall_out)) idle_cycles = 0;
			else idle_cycles++;
			if (valid_out && !stall_out) begin
				if (filtered_q.size() == 0)
					report($sformatf("unexpected result r%0d c%0d", out_row, out_col));
				else begin
					e = filtered_q.pop_front();
					if (out_pixel !== e.level)
						report($sformatf("level r%0d c%0d got %0d want %0d",
							e.row, e.col, out_pixel, e.level));
					if (out_row !== e.row)
						report($sformatf("row got %0d want %0d", out_row, e.row));
					if (out_col !== e.col)
						report($sformatf("col got %0d want %0d", out_col, e.col));
					if (run_last !== e.last)
						report($sformatf("last r%0d c%0d got %0b", e.row, e.col, run_last));
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic write_reg(input c3zpc_pkg::reg_idx_t idx, input logic [62:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			c3zpc_pkg::REG_KERNEL: m_kernel = val;
			c3zpc_pkg::REG_DIVISOR: m_div = val[7:0];
			c3zpc_pkg::REG_OFFSET: m_off = val[10:0];
			c3zpc_pkg::REG_MAX: m_max = val[15:0];
			c3zpc_pkg::REG_WIDTH: begin m_width = val[10:0]; m_row = 0; m_col = 0; end
			c3zpc_pkg::REG_HEIGHT: begin m_height = val[15:0]; m_row = 0; m_col = 0; end
			default: ;
		endcase
	endtask

	// Wait until every pixel is taken and every result seen, then let the divider drain
	task automatic drain();
		while (pixel_q.size() > 0 || valid_in || filtered_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [62:0] pack_kernel(input int k [9]);
		logic [62:0] v;
		v = '0;
		for (int i = 0; i < 9; i++) v[7*i +: 7] = k[i][6:0];
		return v;
	endfunction

	task automatic queue_frame(input int n, input int mode, input logic [15:0] maxv);
		for (int i = 0; i < n; i++)
			case (mode)
				0: pixel_q.insert(pixel_q.size(), 16'($urandom_range(maxv, 0)));
				1: pixel_q.insert(pixel_q.size(), 16'hFFFF);
				2: pixel_q.insert(pixel_q.size(), 16'h0000);
				default: pixel_q.insert(pixel_q.size(), 16'($urandom));
			endcase
	endtask

	task automatic set_frame(input int w, input int h);
		write_reg(c3zpc_pkg::REG_WIDTH, 63'(w));
		write_reg(c3zpc_pkg::REG_HEIGHT, 63'(h));
	endtask

	initial begin
		int k [9];
		int w, h;
		m_kernel = 63'(1) << 28; m_div = 8'd1; m_off = '0; m_max = 16'd255;
		m_width = 11'd640; m_height = 16'd480; m_row = 0; m_col = 0;
		for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) m_win[i][j] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: sharpen kernel, full white frame clamps at the upper limit
		k = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
		write_reg(c3zpc_pkg::REG_KERNEL, pack_kernel(k));
		write_reg(c3zpc_pkg::REG_MAX, 63'd65535);
		set_frame(3, 3);
		queue_frame(9, 1, 16'hFFFF);
		drain();

		// Extreme coefficients, largest divisor, negative offset, black then white
		k = '{-64, 63, -64, 63, -64, 63, -64, 63, -64};
		write_reg(c3zpc_pkg::REG_KERNEL, pack_kernel(k));
		write_reg(c3zpc_pkg::REG_DIVISOR, 63'd255);
		write_reg(c3zpc_pkg::REG_OFFSET, 63'h400);
		write_reg(c3zpc_pkg::REG_MAX, 63'd1);
		set_frame(2, 2);
		queue_frame(4, 2, 16'd0);
		queue_frame(4, 1, 16'd0);
		drain();

		// Zero divisor, zero width and height, oversize width; positive offset
		write_reg(c3zpc_pkg::REG_DIVISOR, 63'd0);
		write_reg(c3zpc_pkg::REG_OFFSET, 63'd1023);
		write_reg(c3zpc_pkg::REG_MAX, 63'd65535);
		set_frame(0, 0);
		queue_frame(3, 3, 16'd0);
		drain();
		set_frame(2047, 1);
		queue_frame(4, 3, 16'd0);
		drain();
		set_frame(1, 4);
		queue_frame(4, 3, 16'd0);
		drain();

		// Random phases; the second holds the receiver off long enough to back up
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(c3zpc_pkg::REG_KERNEL, 63'({$urandom, $urandom}));
			write_reg(c3zpc_pkg::REG_DIVISOR, 63'($urandom_range(255, 0)));
			write_reg(c3zpc_pkg::REG_OFFSET, 63'($urandom));
			write_reg(c3zpc_pkg::REG_MAX, 63'(ph == 0 ? 65535 : $urandom_range(65535, 1)));
			w = $urandom_range(5, 1);
			h = $urandom_range(5, 1);
			set_frame(w, h);
			stall_pat_on = ($urandom_range(3) != 0);
			if (ph == 1) hold_arm = 1'b1;
			queue_frame(11, (ph == 3) ? 3 : 0, m_max);
			drain();
			hold_arm = 1'b0;
		end
		stall_pat_on = 1'b1;

		// Back to the identity kernel and its register defaults
		write_reg(c3zpc_pkg::REG_KERNEL, 63'(1) << 28);
		write_reg(c3zpc_pkg::REG_DIVISOR, 63'd1);
		write_reg(c3zpc_pkg::REG_OFFSET, 63'd0);
		write_reg(c3zpc_pkg::REG_MAX, 63'd255);
		set_frame(4, 3);
		queue_frame(12, 3, 16'd0);
		drain();

		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ files.f @@
rtl/c3zpc_pkg.sv
rtl/c3zpc_div.sv
rtl/conv3x3_zero_pad_clamp.sv
tb/testbench.sv
